### rtl/fprpf_pkg.sv
package fprpf_pkg;

    localparam int MAX_PRIMARIES_DEF = 64;
    localparam int COORD_BITS_DEF    = 24;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int POS_W      = 24;
    localparam int SEL_W      = 32;
    localparam int GIDX_W     = 24;
    localparam int RANK_W     = 8;
    localparam int SLOT_W     = 6;
    localparam int DIST_W     = 24;
    localparam int MCNT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // radius is 24 bits, so any match has a squared distance below 2^48
    localparam int RAD_W  = 2 * DIST_W;
    localparam int ROOT_W = DIST_W;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SEL  = 2'd0,
        CFG_MAX_SEL  = 2'd1,
        CFG_MAX_DIST = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_op                op;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [SEL_W-1:0]   selection;
        logic [GIDX_W-1:0]  galaxy_index;
        logic [RANK_W-1:0]  origin_rank;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  primary_slot;
        logic [RANK_W-1:0]  primary_rank;
        logic [GIDX_W-1:0]  secondary_index;
        logic [DIST_W-1:0]  pair_distance;
        logic [MCNT_W-1:0]  match_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

endpackage

### rtl/fprpf_if.sv
interface fprpf_in_if;
    logic                valid;
    logic                ready;
    fprpf_pkg::t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface fprpf_out_if;
    logic                 valid;
    logic                 ready;
    fprpf_pkg::t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface fprpf_cfg_if;
    logic                 valid;
    logic                 ready;
    fprpf_pkg::t_cfg_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### rtl/fprpf_sqrt.sv
module fprpf_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [fprpf_pkg::RAD_W-1:0]    i_radicand,
    output logic                           o_done,
    output logic [fprpf_pkg::ROOT_W-1:0]   o_root
);
    import fprpf_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // restoring square root, one result bit per cycle
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(ROOT_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= take ? rem_sh - trial : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], take};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/fixed_radius_pair_finder_unit.sv
// Channel  | Dir | Payload                                    | Transfer
// i_in     | in  | op, pos_x/y/z, selection, galaxy_index,    | valid & ready
//          |     | origin_rank                                |
// o_out    | out | primary_slot, primary_rank, secondary_index,| valid & ready
//          |     | pair_distance, match_count, last           |
// i_cfg    | in  | register index, write data                 | valid & ready
//
// Load, clear and unselected searches complete in the idle state. A search
// walks the table one slot at a time through the primary memory: read,
// multiply and compare states per stored primary, plus per match the sqrt unit
// (24 root bits at one per cycle) and counter write back, then a final flush.
// One result is held back so the last flag is known; output stalls hold the walk.
// Reset (synchronous) empties the table and loads the register defaults.
module fixed_radius_pair_finder_unit #(
    parameter int MAX_PRIMARIES = fprpf_pkg::MAX_PRIMARIES_DEF,
    parameter int COORD_BITS    = fprpf_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS    = fprpf_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fprpf_in_if.sink    i_in,
    fprpf_cfg_if.sink   i_cfg,
    fprpf_out_if.source o_out
);
    import fprpf_pkg::*;

    localparam int AW  = (MAX_PRIMARIES > 1) ? $clog2(MAX_PRIMARIES) : 1;
    localparam int FW  = $clog2(MAX_PRIMARIES + 1);
    localparam int CW  = COORD_BITS;
    localparam int SQW = 2 * CW;
    localparam int SW  = 2 * CW + 2;
    localparam int LW  = 2 * DIST_W;

    typedef struct packed {
        logic [CW-1:0]     x;
        logic [CW-1:0]     y;
        logic [CW-1:0]     z;
        logic [RANK_W-1:0] rank;
    } t_prim;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL, S_CMP, S_SQRT, S_EMIT, S_FLUSH
    } t_state;

    t_prim                 prim_mem [MAX_PRIMARIES];
    logic [COUNT_BITS-1:0] cnt_mem  [MAX_PRIMARIES];

    t_state                r_state;
    logic [FW-1:0]         r_fill;
    logic [AW-1:0]         r_slot;
    t_prim                 r_rd;
    logic [COUNT_BITS-1:0] r_cnt_rd;

    logic signed [SEL_W-1:0] r_min_sel, r_max_sel;
    logic [DIST_W-1:0]       r_max_dist;
    logic [LW-1:0]           r_lim;

    logic [CW-1:0]     r_cx, r_cy, r_cz;
    logic [GIDX_W-1:0] r_gidx;
    logic [SQW-1:0]    r_sqx, r_sqy, r_sqz;

    t_out_item r_pend;
    logic      r_pend_valid;
    t_out_item r_out;
    logic      r_out_valid;

    logic sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;

    logic in_xfer, out_free, is_load, is_search, selected, last_slot;
    logic [CW+POS_W-1:0] ext_x, ext_y, ext_z;
    logic [CW-1:0] in_x, in_y, in_z, dx, dy, dz;
    logic [SW-1:0] d2_sum;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [AW+SLOT_W-1:0] slot_ext;
    logic [COUNT_BITS+MCNT_W-1:0] cnt_ext;
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic [COUNT_BITS-1:0] cnt_wd;
    t_out_item pend_last;
    logic out_load;

    always_comb begin
        in_xfer   = i_in.valid && i_in.ready;
        out_free  = !r_out_valid || o_out.ready;
        ext_x     = {{CW{1'b0}}, i_in.item.pos_x};
        ext_y     = {{CW{1'b0}}, i_in.item.pos_y};
        ext_z     = {{CW{1'b0}}, i_in.item.pos_z};
        in_x      = ext_x[CW-1:0];
        in_y      = ext_y[CW-1:0];
        in_z      = ext_z[CW-1:0];
        is_load   = in_xfer && (i_in.item.op == OP_LOAD)
                    && (r_fill < FW'(MAX_PRIMARIES));
        is_search = in_xfer && (i_in.item.op == OP_SEARCH);
        selected  = ($signed(i_in.item.selection) >= r_min_sel)
                    && ($signed(i_in.item.selection) < r_max_sel);
        last_slot = (FW'(r_slot) + FW'(1)) == r_fill;
        dx = (r_rd.x >= r_cx) ? r_rd.x - r_cx : r_cx - r_rd.x;
        dy = (r_rd.y >= r_cy) ? r_rd.y - r_cy : r_cy - r_rd.y;
        dz = (r_rd.z >= r_cz) ? r_rd.z - r_cz : r_cz - r_rd.z;
        d2_sum = SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz);
        cnt_inc = (r_cnt_rd == {COUNT_BITS{1'b1}}) ? r_cnt_rd : r_cnt_rd + 1'b1;
        slot_ext = {{SLOT_W{1'b0}}, r_slot};
        cnt_ext  = {{MCNT_W{1'b0}}, cnt_inc};
        // sqrt takes the fresh sum in the same cycle as the range compare
        sq_start = (r_state == S_CMP) && (d2_sum <= SW'(r_lim));
        pend_last      = r_pend;
        pend_last.last = 1'b1;
        out_load = r_pend_valid && out_free
                   && ((r_state == S_EMIT) || (r_state == S_FLUSH));
        // memory write: load fills a slot, emit writes the bumped counter back
        mem_we = 1'b0;
        mem_wa = r_slot;
        cnt_wd = cnt_inc;
        if (is_load) begin
            mem_we = 1'b1;
            mem_wa = r_fill[AW-1:0];
            cnt_wd = '0;
        end else if (r_state == S_EMIT && (!r_pend_valid || out_free)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_load) begin
            prim_mem[mem_wa] <= '{x: in_x, y: in_y, z: in_z,
                                  rank: i_in.item.origin_rank};
        end
        if (mem_we) begin
            cnt_mem[mem_wa] <= cnt_wd;
        end
        r_rd     <= prim_mem[r_slot];
        r_cnt_rd <= cnt_mem[r_slot];
    end

    fprpf_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (d2_sum[RAD_W-1:0]),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sel <= {1'b1, {(SEL_W-1){1'b0}}};
            r_max_sel <= {1'b0, {(SEL_W-1){1'b1}}};
            r_max_dist <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.item.index)
                CFG_MIN_SEL:  r_min_sel  <= i_cfg.item.data;
                CFG_MAX_SEL:  r_max_sel  <= i_cfg.item.data;
                CFG_MAX_DIST: r_max_dist <= i_cfg.item.data[DIST_W-1:0];
                default: ;
            endcase
        end
        r_lim <= r_max_dist * r_max_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_slot       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (is_load) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    if (in_xfer && i_in.item.op == OP_CLEAR) begin
                        r_fill <= '0;
                    end
                    if (is_search && selected && r_fill != '0) begin
                        r_cx    <= in_x;
                        r_cy    <= in_y;
                        r_cz    <= in_z;
                        r_gidx  <= i_in.item.galaxy_index;
                        r_slot  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_MUL;
                S_MUL: begin
                    r_sqx   <= dx * dx;
                    r_sqy   <= dy * dy;
                    r_sqz   <= dz * dz;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (d2_sum <= SW'(r_lim)) begin
                        r_state <= S_SQRT;
                    end else if (last_slot) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            r_out <= r_pend;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend <= '{primary_slot:    slot_ext[SLOT_W-1:0],
                                    primary_rank:    r_rd.rank,
                                    secondary_index: r_gidx,
                                    pair_distance:   sq_root,
                                    match_count:     cnt_ext[MCNT_W-1:0],
                                    last:            1'b0};
                        if (last_slot) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out        <= pend_last;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

endmodule

### test/fixed_radius_pair_finder_unit_tb.sv
`timescale 1ns / 1ps

module fixed_radius_pair_finder_unit_tb;
    import fprpf_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         N_SLOTS    = MAX_PRIMARIES_DEF;
    localparam int         DRAIN_WAIT = 250;   // full table walk with no match
    localparam int         QUIET_MAX  = 20000;
    localparam int         LONG_HOLD  = 400;
    localparam int         N_PHASES   = 4;
    localparam int         PHASE_LEN  = 30;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fprpf_in_if  in_ch ();
    fprpf_cfg_if cfg_ch ();
    fprpf_out_if out_ch ();

    fixed_radius_pair_finder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the block
    logic [POS_W-1:0]  tbl_x [N_SLOTS];
    logic [POS_W-1:0]  tbl_y [N_SLOTS];
    logic [POS_W-1:0]  tbl_z [N_SLOTS];
    logic [RANK_W-1:0] tbl_rank [N_SLOTS];
    logic [MCNT_W-1:0] tbl_hits [N_SLOTS];
    int                tbl_fill;
    int                sel_lo;
    int                sel_hi;
    logic [DIST_W-1:0] radius;

    t_out_item pair_q [$];
    int        n_errors;
    int        n_items;
    int        n_pairs;
    int        n_cfg;
    int        quiet;
    bit        burst;
    bit        long_hold_req;

    typedef struct {
        bit        is_cfg;
        t_cfg_idx  ci;
        logic [CFG_DATA_W-1:0] cd;
        t_in_item  it;
        int        n_typed;   // -1: predicted, 0: no pair, 1: typed pair
        t_out_item pair;
    } t_row;

    t_row rows [$];

    function automatic logic [DIST_W-1:0] floor_root(longint unsigned v);
        logic [DIST_W:0] r;
        logic [DIST_W:0] t;
        r = '0;
        for (int b = DIST_W; b >= 0; b--) begin
            t = r | (25'd1 << b);
            if (longint'(t) * longint'(t) <= v)
                r = t;
        end
        return r[DIST_W-1:0];
    endfunction

    function automatic longint unsigned gap_sq(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        longint unsigned d;
        d = (a >= b) ? longint'(a - b) : longint'(b - a);
        return d * d;
    endfunction

    // apply one accepted item to the shadow; returns the pairs it causes
    function automatic void pair_predict(t_in_item it, ref t_out_item res [$]);
        longint unsigned lim;
        longint unsigned d2;
        t_out_item p;
        res.delete();
        case (it.op)
            OP_LOAD: begin
                if (tbl_fill < N_SLOTS) begin
                    tbl_x[tbl_fill]    = it.pos_x;
                    tbl_y[tbl_fill]    = it.pos_y;
                    tbl_z[tbl_fill]    = it.pos_z;
                    tbl_rank[tbl_fill] = it.origin_rank;
                    tbl_hits[tbl_fill] = '0;
                    tbl_fill++;
                end
            end
            OP_CLEAR: tbl_fill = 0;
            OP_SEARCH: begin
                if (signed'(it.selection) >= sel_lo && signed'(it.selection) < sel_hi) begin
                    lim = longint'(radius) * longint'(radius);
                    for (int s = 0; s < tbl_fill; s++) begin
                        d2 = gap_sq(tbl_x[s], it.pos_x) + gap_sq(tbl_y[s], it.pos_y)
                           + gap_sq(tbl_z[s], it.pos_z);
                        if (d2 <= lim) begin
                            if (tbl_hits[s] != '1)
                                tbl_hits[s]++;
                            p.primary_slot    = s[SLOT_W-1:0];
                            p.primary_rank    = tbl_rank[s];
                            p.secondary_index = it.galaxy_index;
                            p.pair_distance   = floor_root(d2);
                            p.match_count     = tbl_hits[s];
                            p.last            = 1'b0;
                            res.push_back(p);
                        end
                    end
                    if (res.size() > 0)
                        res[res.size()-1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.item.index <= idx;
        cfg_ch.item.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_MIN_SEL:  sel_lo = signed'(data);
            CFG_MAX_SEL:  sel_hi = signed'(data);
            CFG_MAX_DIST: radius = data[DIST_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic drain();
        while (pair_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // typed: -1 take predicted pairs, 0 expect none, 1 expect the given pair
    task automatic send(t_in_item it, int typed, t_out_item pair);
        int gap;
        t_out_item res [$];
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        pair_predict(it, res);
        if (typed < 0)
            foreach (res[i]) pair_q.push_back(res[i]);
        else if (typed == 1)
            pair_q.push_back(pair);
        n_items++;
    endtask

    function automatic t_in_item make_item(logic [1:0] op, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z,
                                           logic [31:0] sel, logic [31:0] g,
                                           logic [31:0] rk);
        t_in_item it;
        it.op = t_op'(op);
        it.pos_x = POS_W'(x);
        it.pos_y = POS_W'(y);
        it.pos_z = POS_W'(z);
        it.selection = SEL_W'(sel);
        it.galaxy_index = GIDX_W'(g);
        it.origin_rank = RANK_W'(rk);
        return it;
    endfunction

    function automatic void add_row(t_in_item it, int typed, t_out_item pair);
        t_row r;
        r.is_cfg = 1'b0;
        r.it = it;
        r.n_typed = typed;
        r.pair = pair;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r.is_cfg = 1'b1;
        r.ci = idx;
        r.cd = data;
        rows.push_back(r);
    endfunction

    function automatic t_out_item pair_of(int slot, int rk, int g, int d, int cnt);
        t_out_item p;
        p.primary_slot    = SLOT_W'(slot);
        p.primary_rank    = RANK_W'(rk);
        p.secondary_index = GIDX_W'(g);
        p.pair_distance   = DIST_W'(d);
        p.match_count     = MCNT_W'(cnt);
        p.last            = 1'b1;
        return p;
    endfunction

    function automatic void field_check(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.item;
            n_pairs++;
            if (pair_q.size() == 0) begin
                $display("%0t: unexpected pair, expected none, actual %h", $time, a);
                n_errors++;
            end else begin
                e = pair_q.pop_front();
                field_check("primary_slot", e.primary_slot, a.primary_slot);
                field_check("primary_rank", e.primary_rank, a.primary_rank);
                field_check("secondary_index", e.secondary_index, a.secondary_index);
                field_check("pair_distance", e.pair_distance, a.pair_distance);
                field_check("match_count", e.match_count, a.match_count);
                field_check("last", e.last, a.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("Verification failed");
            $finish;
        end
    end

    // result side stalls
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            stall = burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        t_out_item none;
        t_in_item it;
        logic [POS_W-1:0] cx, cy, cz;
        logic [SEL_W-1:0] sel;
        int op_pick;
        int spread;

        in_ch.valid   = 1'b0;
        in_ch.item    = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.item   = '0;
        none          = '0;
        n_errors      = 0;
        n_items       = 0;
        n_pairs       = 0;
        n_cfg         = 0;
        quiet         = 0;
        burst         = 1'b0;
        long_hold_req = 1'b0;
        tbl_fill      = 0;
        sel_lo        = 32'sh8000_0000;
        sel_hi        = 32'sh7fff_ffff;
        radius        = '0;

        // directed: radius starts at zero, so only coincident points pair up
        add_row(make_item(OP_SEARCH, 0, 0, 0, 0, 1, 0), 0, none);
        add_row(make_item(OP_LOAD, 0, 0, 0, 0, 0, 8'hff), 0, none);
        add_row(make_item(OP_SEARCH, 0, 0, 0, 0, 24'hffffff, 0), 1,
                pair_of(0, 8'hff, 24'hffffff, 0, 1));
        add_row(make_item(OP_SEARCH, 1, 0, 0, 0, 5, 0), 0, none);
        add_row(make_item(OP_UNUSED, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_item(OP_LOAD, '1, '1, '1, '1, '1, 0), 0, none);
        add_row(make_item(OP_SEARCH, '1, '1, '1, 0, 0, 8'h5a), 1,
                pair_of(1, 0, 0, 0, 1));
        // selection at the exclusive upper bound
        add_row(make_item(OP_SEARCH, 0, 0, 0, 32'h7fff_ffff, 7, 0), 0, none);
        add_row(make_item(OP_SEARCH, 0, 0, 0, 32'h8000_0000, 9, 0), 1,
                pair_of(0, 8'hff, 9, 0, 2));
        add_cfg(CFG_MAX_DIST, 24'hffffff);
        add_row(make_item(OP_SEARCH, 0, 0, 0, 0, 24'h123456, 0), -1, none);
        add_row(make_item(OP_SEARCH, 24'h800000, 24'h800000, 24'h800000, 0, 3, 0), -1, none);
        add_row(make_item(OP_SEARCH, '1, 0, '1, 0, 4, 0), -1, none);
        add_row(make_item(OP_CLEAR, '1, '1, '1, '1, '1, '1), 0, none);
        add_row(make_item(OP_SEARCH, 0, 0, 0, 0, 6, 0), 0, none);
        add_row(make_item(OP_LOAD, 24'h000300, 24'h000400, 0, 0, 0, 8'h11), 0, none);
        add_cfg(CFG_MIN_SEL, 32'h0001_0000);
        add_cfg(CFG_MAX_SEL, 32'h0002_0000);
        add_row(make_item(OP_SEARCH, 0, 0, 0, 32'h0000_ffff, 2, 0), 0, none);
        add_row(make_item(OP_SEARCH, 0, 0, 0, 32'h0001_0000, 2, 0), 1,
                pair_of(0, 8'h11, 2, 24'h000500, 1));
        add_row(make_item(OP_SEARCH, 0, 0, 0, 32'h0001_ffff, 8, 0), -1, none);
        add_row(make_item(OP_SEARCH, 0, 0, 0, 32'h0002_0000, 8, 0), 0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                in_ch.valid <= 1'b0;
                drain();
                cfg_write(rows[i].ci, rows[i].cd);
            end else begin
                send(rows[i].it, rows[i].n_typed, rows[i].pair);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            in_ch.valid <= 1'b0;
            drain();
            case (ph)
                0: begin
                    cfg_write(CFG_MIN_SEL, 32'h8000_0000);
                    cfg_write(CFG_MAX_SEL, 32'h7fff_ffff);
                    cfg_write(CFG_MAX_DIST, $urandom_range(24'h000100, 24'h00ffff));
                end
                1: begin
                    cfg_write(CFG_MIN_SEL, 32'hffff_0000);
                    cfg_write(CFG_MAX_SEL, 32'h0001_0000);
                    cfg_write(CFG_MAX_DIST, 24'hffffff);
                end
                2: begin
                    cfg_write(CFG_MIN_SEL, $urandom);
                    cfg_write(CFG_MAX_SEL, 32'h7fff_ffff);
                    cfg_write(CFG_MAX_DIST, $urandom_range(0, 24'h000fff));
                end
                default: begin
                    cfg_write(CFG_MIN_SEL, 32'h8000_0000);
                    cfg_write(CFG_MAX_SEL, 32'h8000_0000);   // empty window
                    cfg_write(CFG_MAX_DIST, 24'h004000);
                    drain();
                    for (int k = 0; k < 6; k++)
                        send(make_item(OP_SEARCH, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom), -1, none);
                    in_ch.valid <= 1'b0;
                    drain();
                    cfg_write(CFG_MAX_SEL, 32'h7fff_ffff);
                end
            endcase
            burst = (ph == 2);
            if (ph == 1)
                long_hold_req = 1'b1;
            cx = POS_W'($urandom);
            cy = POS_W'($urandom);
            cz = POS_W'($urandom);
            spread = radius / 2 + 1;
            // phase 1 opens by filling the table past capacity
            if (ph == 1)
                for (int k = 0; k < N_SLOTS + 2; k++)
                    send(make_item(OP_LOAD, cx + $urandom_range(0, 255), cy, cz,
                                   $urandom, $urandom, $urandom), -1, none);
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (ph == 0 && k == 20) begin
                    in_ch.valid <= 1'b0;
                    while (pair_q.size() > 0) @(posedge i_clk);
                end
                op_pick = $urandom_range(0, 99);
                sel = ($urandom_range(0, 3) == 0) ? $urandom
                    : (ph == 1 ? $urandom_range(0, 32'hffff) : sel_lo + $urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0)
                    it = make_item(OP_LOAD, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
                else
                    it = make_item(OP_LOAD, cx + $urandom_range(0, spread),
                                   cy + $urandom_range(0, spread),
                                   cz + $urandom_range(0, spread), sel, $urandom, $urandom);
                if (op_pick < 45)
                    it.op = OP_SEARCH;
                else if (op_pick < 50)
                    it.op = (tbl_fill > 40) ? OP_CLEAR : OP_LOAD;
                else if (op_pick < 53)
                    it.op = t_op'(OP_UNUSED);
                else if (op_pick < 55)
                    it.op = OP_CLEAR;
                send(it, -1, none);
            end
        end

        in_ch.valid <= 1'b0;
        burst = 1'b0;
        drain();

        $display("%0d items, %0d pairs, %0d register writes; radius, window, full table",
                 n_items, n_pairs, n_cfg);
        $display("and idle/stall pressure exercised with %0d mismatches", n_errors);
        if (n_errors == 0 && pair_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/fprpf_pkg.sv
rtl/fprpf_if.sv
rtl/fprpf_sqrt.sv
rtl/fixed_radius_pair_finder_unit.sv
test/fixed_radius_pair_finder_unit_tb.sv
